// ----- hdl/tif_pkg.sv -----
package tif_pkg;

  localparam int PathsW     = 3;
  localparam int CntW       = 3;
  localparam int SampleW    = 16;
  localparam int ShiftW     = 3;
  localparam int CodeW      = 16;
  localparam int WordW      = 24;
  localparam int HalfW      = 12;
  localparam int MaxTones   = 5;
  localparam int QueueDepth = 2;

  localparam logic [PathsW-1:0] PathsReset = 3'd1;
  localparam logic [PathsW-1:0] PathsMin   = 3'd1;
  localparam logic [PathsW-1:0] PathsMax   = 3'd4;
  localparam logic [CodeW-1:0]  OffsetOvf  = 16'hC000;
  localparam int                OffsetLim  = 10000;
  localparam int                AmpHigh    = 1500;
  localparam int                AmpMedium  = 800;
  localparam int                AmpFloor   = 10;

  typedef enum logic [1:0] {
    OpOffset = 2'd0,
    OpNoTone = 2'd1,
    OpTone   = 2'd2,
    OpToneB  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KindOffset = 2'd0,
    KindTone   = 2'd1,
    KindNone   = 2'd2,
    KindDrop   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    QualHigh    = 2'd0,
    QualMedium  = 2'd1,
    QualLow     = 2'd2,
    QualUnknown = 2'd3
  } qual_e;

  typedef struct packed {
    kind_e                     kind;
    logic [CntW-1:0]           idx;
    logic [ShiftW-1:0]         shift;
    logic signed [SampleW-1:0] a;
    logic signed [SampleW-1:0] b;
  } item_t;

  typedef struct packed {
    kind_e            kind;
    logic [CodeW-1:0] code;
    logic [CntW-1:0]  idx;
    logic [WordW-1:0] word;
    qual_e            qual;
  } result_t;

endpackage

// ----- hdl/tif_front.sv -----
module tif_front
  import tif_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [PathsW-1:0]         paths_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [1:0]                op_i,
  input  logic                      step_start_i,
  input  logic signed [SampleW-1:0] raw_i,
  input  logic signed [SampleW-1:0] i_i,
  input  logic signed [SampleW-1:0] q_i,
  input  logic                      full_i,
  output logic                      push_o,
  output item_t                     item_o
);

  logic [CntW-1:0]   cnt_q, cnt_d, cnt_cur;
  logic [PathsW-1:0] paths_c;
  logic [CntW:0]     limit;
  logic              drop;
  logic [SampleW-1:0] mag_i, mag_q, mag_m;
  logic [ShiftW-1:0]  shift;
  op_e               op;

  assign op      = op_e'(op_i);
  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;
  assign cnt_cur = step_start_i ? '0 : cnt_q;

  always_comb begin
    if (paths_i < PathsMin) begin
      paths_c = PathsMin;
    end else if (paths_i > PathsMax) begin
      paths_c = PathsMax;
    end else begin
      paths_c = paths_i;
    end
    limit = {1'b0, paths_c} + (CntW+1)'(1);
    if (limit > (CntW+1)'(MaxTones)) begin
      limit = (CntW+1)'(MaxTones);
    end
  end

  assign drop = {1'b0, cnt_cur} >= limit;

  assign mag_i = i_i[SampleW-1] ? (~i_i + 1'b1) : i_i;
  assign mag_q = q_i[SampleW-1] ? (~q_i + 1'b1) : q_i;
  assign mag_m = (mag_q > mag_i) ? mag_q : mag_i;

  always_comb begin
    priority if (mag_m[15]) begin
      shift = 3'd5;
    end else if (mag_m[14]) begin
      shift = 3'd4;
    end else if (mag_m[13]) begin
      shift = 3'd3;
    end else if (mag_m[12]) begin
      shift = 3'd2;
    end else if (mag_m[11]) begin
      shift = 3'd1;
    end else begin
      shift = 3'd0;
    end
  end

  always_comb begin
    item_o       = '0;
    item_o.kind  = KindNone;
    cnt_d        = cnt_q;
    if (push_o) begin
      cnt_d = cnt_cur;
    end
    unique case (op)
      OpOffset: begin
        item_o.kind = KindOffset;
        item_o.a    = raw_i;
      end
      OpNoTone: begin
        item_o.kind = KindNone;
      end
      OpTone, OpToneB: begin
        item_o.idx = cnt_cur;
        if (drop) begin
          item_o.kind = KindDrop;
        end else begin
          item_o.kind  = KindTone;
          item_o.shift = shift;
          item_o.a     = i_i;
          item_o.b     = q_i;
          if (push_o) begin
            cnt_d = cnt_cur + 1'b1;
          end
        end
      end
      default: begin
        item_o.kind = KindNone;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hdl/tif_queue.sv -----
module tif_queue
  import tif_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not advance on request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

endmodule

// ----- hdl/tif_back.sv -----
module tif_back
  import tif_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  item_t   item_i,
  output logic    pop_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic                      valid_q, valid_d;
  result_t                   res_q, res_d;
  logic signed [20:0]        prod;
  logic signed [20:0]        prod_adj;
  logic signed [18:0]        f;
  logic signed [SampleW-1:0] si, sq;
  logic [HalfW-1:0]          i12, q12, mi, mq;
  logic [HalfW:0]            amp;

  assign pop_o = valid_i && (!valid_q || ready_i);

  assign prod     = 21'(item_i.a) * 21'sd25;
  assign prod_adj = prod[20] ? prod + 21'sd3 : prod;
  assign f        = 19'(prod_adj >>> 2);

  assign si  = item_i.a >>> item_i.shift;
  assign sq  = item_i.b >>> item_i.shift;
  assign i12 = si[HalfW-1:0];
  assign q12 = sq[HalfW-1:0];
  assign mi  = i12[HalfW-1] ? (~i12 + 1'b1) : i12;
  assign mq  = q12[HalfW-1] ? (~q12 + 1'b1) : q12;
  assign amp = {1'b0, mi} + {1'b0, mq};

  always_comb begin
    res_d      = '0;
    res_d.kind = item_i.kind;
    res_d.qual = QualUnknown;
    unique case (item_i.kind)
      KindOffset: begin
        if (f >= -19'(OffsetLim) && f <= 19'(OffsetLim)) begin
          res_d.code = {1'b0, f[14:0]};
        end else begin
          res_d.code = OffsetOvf;
        end
      end
      KindTone: begin
        res_d.idx  = item_i.idx;
        res_d.word = {q12, i12};
        priority if (amp < (HalfW+1)'(AmpFloor)) begin
          res_d.qual = QualUnknown;
        end else if (amp > (HalfW+1)'(AmpHigh)) begin
          res_d.qual = QualHigh;
        end else if (amp > (HalfW+1)'(AmpMedium)) begin
          res_d.qual = QualMedium;
        end else begin
          res_d.qual = QualLow;
        end
      end
      KindDrop: begin
        res_d.idx = item_i.idx;
      end
      KindNone: begin
        res_d.kind = KindNone;
      end
      default: begin
        res_d.kind = KindNone;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.kind == KindTone) |-> res_q.idx < CntW'(MaxTones))
    else $error("tone slot beyond limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.kind != KindTone) |-> (res_q.qual == QualUnknown && res_q.word == '0))
    else $error("tone fields set on non-tone result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> valid_q)
    else $error("result lost while stalled");

endmodule

// ----- hdl/tone_iq_result_formatter.sv -----
// Tone and frequency-offset result formatter for one ranging step.
// Input stream: s_axis_tuser carries op and step_start, s_axis_tdata carries
// the raw offset and the I/Q samples. Each accepted request yields exactly
// one result on the m_axis stream, in order: result_kind on m_axis_tuser,
// offset code, tone slot, packed 24-bit I/Q word and quality on m_axis_tdata.
// An accepted request passes through the queue and is written to the result
// register when the back stage pops it, which raises m_axis_tvalid.
// Throughput: one request per cycle sustained while m_axis_tready is high;
// the front stage numbers tones and finds the normalising shift,
// a two-entry queue sits between it and the back stage, which scales, packs
// and registers.
// A stalled receiver holds the result register; the back stage stops
// popping, the queue fills up to its two entries and s_axis_tready then
// drops, so no request is lost.
// Reset clears the tone counter, empties the queue and output register and
// sets antenna_paths to 1. Write antenna_paths (APB, address 0) only while
// the block is idle; tones beyond antenna_paths (clamped to 1..4) plus one in
// a step come out as overflow results and do not advance the tone counter.
module tone_iq_result_formatter
  import tif_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] raw_freq_offset, [31:16] i_sample, [47:32] q_sample
  input  logic [47:0] s_axis_tdata,
  // [1:0] op, [2] step_start
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] offset_code, [18:16] tone_index, [42:19] phase_word,
  // [44:43] quality, [47:45] zero
  output logic [47:0] m_axis_tdata,
  // [1:0] result_kind
  output logic [1:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [PathsW-1:0] paths_q;
  logic              push, full, pop, q_valid;
  item_t             f_item, q_item;
  result_t           result;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : {{(32-PathsW){1'b0}}, paths_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paths_q <= PathsReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      paths_q <= pwdata[PathsW-1:0];
    end
  end

  tif_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .paths_i      (paths_q),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .op_i         (s_axis_tuser[1:0]),
    .step_start_i (s_axis_tuser[2]),
    .raw_i        (s_axis_tdata[15:0]),
    .i_i          (s_axis_tdata[31:16]),
    .q_i          (s_axis_tdata[47:32]),
    .full_i       (full),
    .push_o       (push),
    .item_o       (f_item)
  );

  tif_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  tif_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .item_i   (q_item),
    .pop_o    (pop),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (result)
  );

  assign m_axis_tuser = result.kind;
  assign m_axis_tdata = {3'b000, result.qual, result.word, result.idx, result.code};

endmodule

// ----- tb/tb_tone_iq_result_formatter.sv -----
`timescale 1ns / 100ps

module tb_tone_iq_result_formatter
  import tif_pkg::*;
;

  localparam logic [2:0] RegAntennaPaths = 3'd0;
  localparam logic [2:0] RegSpare        = 3'd4;
  localparam int         IqLimit         = 2047;
  localparam int         ScaleMul        = 625;
  localparam int         ScaleDiv        = 100;
  localparam int         PhaseItems      = 130;
  localparam int         CycleLimit      = 400000;

  typedef struct {
    op_e                       op;
    bit                        start;
    logic signed [SampleW-1:0] raw;
    logic signed [SampleW-1:0] i_smp;
    logic signed [SampleW-1:0] q_smp;
    bit                        drain;
  } tone_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tone_req_t      requests[$];
  result_t        pending_formats[$];
  tone_req_t      in_flight;
  logic [PathsW-1:0] model_paths = PathsReset;
  logic [CntW-1:0]   tone_cnt = '0;
  bit             calm = 1'b0;
  int             gap_left = 0;
  int             stall_left = 0;
  int             errors = 0;
  int             cycle_count = 0;

  tone_iq_result_formatter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk_i = ~clk_i;

  function automatic int draw_gap();
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic result_t format_request(tone_req_t r);
    result_t           res;
    int                f;
    int                iv;
    int                qv;
    int                m;
    int                sh;
    int                i12;
    int                q12;
    int                amp;
    logic [PathsW-1:0] paths;
    logic [PathsW-1:0] limit;
    res.kind = KindNone;
    res.code = '0;
    res.idx  = '0;
    res.word = '0;
    res.qual = QualUnknown;
    if (r.start) tone_cnt = '0;
    if (r.op == OpOffset) begin
      res.kind = KindOffset;
      f = (int'(r.raw) * ScaleMul) / ScaleDiv;
      if (f >= -OffsetLim && f <= OffsetLim) res.code = {1'b0, f[14:0]};
      else res.code = OffsetOvf;
    end else if (r.op == OpTone || r.op == OpToneB) begin
      paths = model_paths;
      if (paths < PathsMin) paths = PathsMin;
      if (paths > PathsMax) paths = PathsMax;
      limit = paths + 1'b1;
      if (limit > MaxTones) limit = PathsW'(MaxTones);
      res.idx = tone_cnt;
      if (tone_cnt >= limit) begin
        res.kind = KindDrop;
      end else begin
        iv = int'(r.i_smp);
        qv = int'(r.q_smp);
        m = magnitude(iv);
        if (magnitude(qv) > m) m = magnitude(qv);
        sh = 0;
        while (m > IqLimit) begin
          m = m >> 1;
          sh++;
        end
        i12 = iv >>> sh;
        q12 = qv >>> sh;
        res.kind = KindTone;
        res.word = {q12[HalfW-1:0], i12[HalfW-1:0]};
        amp = magnitude(i12) + magnitude(q12);
        if (amp < AmpFloor) res.qual = QualUnknown;
        else if (amp > AmpHigh) res.qual = QualHigh;
        else if (amp > AmpMedium) res.qual = QualMedium;
        else res.qual = QualLow;
        tone_cnt = tone_cnt + 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_formats.push_back(format_request(in_flight));
        gap_left = draw_gap();
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (requests.size() > 0 &&
                     !(requests[0].drain && pending_formats.size() != 0)) begin
          in_flight = requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {in_flight.q_smp, in_flight.i_smp, in_flight.raw};
          s_axis_tuser  <= {in_flight.start, in_flight.op};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_res;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_formats.size() == 0) begin
          $error("result_kind: expected none, got %0d", m_axis_tuser);
          errors++;
        end else begin
          exp_res = pending_formats.pop_front();
          if (m_axis_tuser !== exp_res.kind) begin
            $error("result_kind: expected %0d, got %0d", exp_res.kind, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata[15:0] !== exp_res.code) begin
            $error("offset_code: expected %h, got %h", exp_res.code, m_axis_tdata[15:0]);
            errors++;
          end
          if (m_axis_tdata[18:16] !== exp_res.idx) begin
            $error("tone_index: expected %0d, got %0d", exp_res.idx, m_axis_tdata[18:16]);
            errors++;
          end
          if (m_axis_tdata[42:19] !== exp_res.word) begin
            $error("phase_word: expected %h, got %h", exp_res.word, m_axis_tdata[42:19]);
            errors++;
          end
          if (m_axis_tdata[44:43] !== exp_res.qual) begin
            $error("quality: expected %0d, got %0d", exp_res.qual, m_axis_tdata[44:43]);
            errors++;
          end
          if (m_axis_tdata[47:45] !== 3'b000) begin
            $error("pad: expected 0, got %h", m_axis_tdata[47:45]);
            errors++;
          end
        end
        stall_left = draw_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic tone_req_t make_req(op_e op, bit start, int raw, int iv, int qv);
    tone_req_t r;
    r.op    = op;
    r.start = start;
    r.raw   = raw[SampleW-1:0];
    r.i_smp = iv[SampleW-1:0];
    r.q_smp = qv[SampleW-1:0];
    r.drain = 1'b0;
    return r;
  endfunction

  function automatic int pick_sample();
    int corners[6];
    corners = '{-32768, 32767, 2047, 2048, -2048, -2049};
    case ($urandom_range(0, 4))
      0: return corners[$urandom_range(0, 5)];
      1: return int'($urandom_range(0, 40)) - 20;
      2: return int'($urandom_range(0, 4200)) - 2100;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 40)) - 20 + ($urandom_range(0, 1) ? 1600 : -1600);
      1: return int'($urandom_range(0, 200)) - 100;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic tone_req_t noise_req();
    return make_req(op_e'($urandom_range(0, 3)), $urandom_range(0, 1),
                    $urandom, $urandom, $urandom);
  endfunction

  task automatic wait_idle();
    while (requests.size() != 0 || s_axis_tvalid || pending_formats.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == RegAntennaPaths) model_paths = data[PathsW-1:0];
    @(posedge clk_i);
  endtask

  initial begin
    int        settings[7];
    int        eff;
    int        count;
    int        n_tones;
    tone_req_t r;
    settings = '{7, 0, 4, 2, 5, 3, 1};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    requests.push_back(make_req(OpOffset, 1'b0, 0, 0, 0));
    requests.push_back(make_req(OpOffset, 1'b0, 32767, -1, 0));
    requests.push_back(make_req(OpOffset, 1'b0, -32768, 0, -1));
    requests.push_back(make_req(OpOffset, 1'b0, 1600, 0, 0));
    requests.push_back(make_req(OpOffset, 1'b0, 1601, 0, 0));
    requests.push_back(make_req(OpOffset, 1'b0, -1600, 0, 0));
    requests.push_back(make_req(OpOffset, 1'b0, -1601, 0, 0));
    requests.push_back(make_req(OpOffset, 1'b0, -1, 0, 0));
    requests.push_back(make_req(OpOffset, 1'b0, 15, 0, 0));
    requests.push_back(make_req(OpNoTone, 1'b0, $urandom, $urandom, $urandom));
    requests.push_back(make_req(OpTone, 1'b1, 0, 0, 0));
    requests.push_back(make_req(OpToneB, 1'b0, 0, -32768, 32767));
    requests.push_back(make_req(OpTone, 1'b0, 0, 100, 100));
    requests.push_back(make_req(OpToneB, 1'b0, -1, 5, 5));
    requests.push_back(make_req(OpTone, 1'b1, 0, 2047, 0));
    requests.push_back(make_req(OpTone, 1'b1, 0, 900, -1));
    requests.push_back(make_req(OpTone, 1'b1, 0, 10, 0));
    requests.push_back(make_req(OpTone, 1'b1, 0, 9, 0));
    requests.push_back(make_req(OpTone, 1'b1, 0, 2047, -2048));
    requests.push_back(make_req(OpTone, 1'b1, 0, -1, -1));
    requests.push_back(make_req(OpToneB, 1'b1, 0, -32768, 0));
    requests.push_back(make_req(OpNoTone, 1'b1, 0, 0, 0));
    requests.push_back(make_req(OpOffset, 1'b1, 32767, 0, 0));
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      cfg_write(RegAntennaPaths, ($urandom & 32'hFFFF_FFF8) | settings[ph]);
      cfg_write(RegSpare, $urandom);
      calm = (ph % 3 == 2);
      eff = settings[ph];
      if (eff < PathsMin) eff = PathsMin;
      if (eff > PathsMax) eff = PathsMax;
      count = 0;
      while (count < PhaseItems) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            r = noise_req();
            r.drain = ($urandom_range(0, 20) == 0);
            requests.push_back(r);
            count++;
          end
          2, 3: begin
            r = make_req($urandom_range(0, 3) ? OpOffset : OpNoTone, 1'b0,
                         pick_offset(), pick_sample(), pick_sample());
            requests.push_back(r);
            count++;
          end
          default: begin
            n_tones = $urandom_range(1, eff + 3);
            for (int k = 0; k < n_tones; k++) begin
              if ($urandom_range(0, 5) == 0) begin
                requests.push_back(make_req(OpOffset, 1'b0, pick_offset(), 0, 0));
                count++;
              end
              r = make_req($urandom_range(0, 1) ? OpTone : OpToneB, k == 0,
                           $urandom, pick_sample(), pick_sample());
              requests.push_back(r);
              count++;
            end
          end
        endcase
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
